@@ rtl/ialu_pkg.sv @@
// ----------------------------------------------------------------------------
// ialu_pkg
// Shared types and constants for the integer ALU with condition codes.
// ----------------------------------------------------------------------------
package ialu_pkg;

    localparam int DATA_W  = 64;
    localparam int LONG_W  = 32;
    localparam int OPA_W   = 32;
    localparam int COUNT_W = 8;
    localparam int TYPE_W  = 4;
    localparam int SIZE_W  = 2;

    // Operation codes; codes above OP_ROT are unused.
    typedef enum logic [TYPE_W-1:0] {
        OP_ADD = 4'd0,
        OP_SUB = 4'd1,
        OP_ADC = 4'd2,
        OP_SBC = 4'd3,
        OP_INC = 4'd4,
        OP_DEC = 4'd5,
        OP_BIC = 4'd6,
        OP_BIS = 4'd7,
        OP_BIT = 4'd8,
        OP_XOR = 4'd9,
        OP_CLR = 4'd10,
        OP_ASH = 4'd11,
        OP_ROT = 4'd12
    } opcode_t;

    typedef enum logic [SIZE_W-1:0] {
        SIZE_BYTE = 2'd0,
        SIZE_WORD = 2'd1,
        SIZE_LONG = 2'd2,
        SIZE_QUAD = 2'd3
    } opsize_t;

    typedef struct packed {
        logic n;
        logic z;
        logic v;
        logic c;
    } flags_t;

endpackage

@@ rtl/ialu_req_if.sv @@
// ----------------------------------------------------------------------------
// ialu_req_if
// Request channel of the integer ALU: one instruction per item.
// ----------------------------------------------------------------------------
interface ialu_req_if;
    import ialu_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [TYPE_W-1:0]         req_type;
    logic [SIZE_W-1:0]         operand_size;
    logic [OPA_W-1:0]          operand_a;
    logic [DATA_W-1:0]         operand_b;
    logic signed [COUNT_W-1:0] shift_count;

    modport source (
        output valid, req_type, operand_size, operand_a, operand_b, shift_count,
        input  ready
    );

    modport sink (
        input  valid, req_type, operand_size, operand_a, operand_b, shift_count,
        output ready
    );
endinterface

@@ rtl/ialu_rsp_if.sv @@
// ----------------------------------------------------------------------------
// ialu_rsp_if
// Result channel of the integer ALU: result value, condition codes and trap.
// ----------------------------------------------------------------------------
interface ialu_rsp_if;
    import ialu_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] result_value;
    logic              flag_negative;
    logic              flag_zero;
    logic              flag_overflow;
    logic              flag_carry;
    logic              trap_request;

    modport source (
        output valid, result_value, flag_negative, flag_zero, flag_overflow,
               flag_carry, trap_request,
        input  ready
    );

    modport sink (
        input  valid, result_value, flag_negative, flag_zero, flag_overflow,
               flag_carry, trap_request,
        output ready
    );
endinterface

@@ rtl/integer_alu_with_condition_codes.sv @@
// ----------------------------------------------------------------------------
// integer_alu_with_condition_codes
// Integer ALU with stored N, Z, V, C condition codes and an overflow trap.
//
// Each request item is one instruction: add, subtract, add or subtract with
// carry, increment, decrement, bit clear, bit set, bit test, exclusive or,
// clear, arithmetic shift or rotate, on a byte, word, long or (for arithmetic
// shift) quad operand. The block accepts one item every clock cycle while not
// stalled: the accepting edge loads the input register, and the result
// register loads from it through a single pass of combinational logic once
// free. The condition code register is updated on the same edge that the
// result register loads, so an add or subtract with carry that directly
// follows another instruction sees that instruction's carry without any
// stall. A result waiting on a stalled output does not stop the input register
// from taking the next item; the pipeline only stops when both registers hold
// items and the result is not taken. The overflow trap enable is a single
// configuration bit, written through cfg_wr_en and cfg_wr_data; the user must
// write it only while the block is idle; the block does not enforce it. Codes
// 13 to 15 return a zero result and the stored condition codes unchanged.
// ----------------------------------------------------------------------------
module integer_alu_with_condition_codes (
    input  logic clk,
    input  logic rst_n,
    ialu_req_if.sink   req,
    ialu_rsp_if.source rsp,
    input  logic cfg_wr_en,
    input  logic cfg_wr_data
);
    import ialu_pkg::*;

    // Configuration.
    logic trap_en_reg;

    // Input register.
    logic                 s1_valid_reg;
    logic [TYPE_W-1:0]    s1_type_reg;
    logic [SIZE_W-1:0]    s1_size_reg;
    logic [OPA_W-1:0]     s1_a_reg;
    logic [DATA_W-1:0]    s1_b_reg;
    logic [COUNT_W-1:0]   s1_count_reg;

    // Stored condition codes.
    flags_t flags_reg;
    flags_t flags_next;

    // Result register.
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [DATA_W-1:0] out_value_reg;
    logic [DATA_W-1:0] out_value_next;
    flags_t            out_flags_reg;
    logic              out_trap_reg;
    logic              out_trap_next;

    // The input register hands its item on whenever the result register is
    // empty or its item is being taken in this cycle.
    logic advance;

    assign advance   = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || advance;

    assign out_valid_next = advance || (out_valid_reg && !rsp.ready);

    // ------------------------------------------------------------------
    // Execute: all of one instruction's work between the two registers.
    // ------------------------------------------------------------------
    always_comb
    begin
        opcode_t           op;
        opsize_t           eff_size;
        logic [DATA_W-1:0] m;
        logic [DATA_W-1:0] sb;
        logic [7:0]        wv;
        logic              is_quad;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic              cin;
        logic [LONG_W:0]   sum;
        logic [LONG_W:0]   diff;
        logic [DATA_W-1:0] r;
        logic              v;
        logic              c;
        logic              cnt_neg;
        logic [7:0]        mag;
        logic              over_w;
        logic [DATA_W-1:0] sx;
        logic [DATA_W-1:0] shl;
        logic [DATA_W-1:0] sxl;
        logic [DATA_W-1:0] chk;
        logic [DATA_W-1:0] rot2;
        logic              valid_op;

        op = opcode_t'(s1_type_reg);

        // Quad is honored only by arithmetic shift; rotate is always long.
        eff_size = opsize_t'(s1_size_reg);
        if (op == OP_ASH)
        begin
            eff_size = (s1_size_reg == SIZE_QUAD) ? SIZE_QUAD : SIZE_LONG;
        end
        else if (op == OP_ROT || s1_size_reg == SIZE_QUAD)
        begin
            eff_size = SIZE_LONG;
        end

        case (eff_size)
            SIZE_BYTE:
            begin
                m  = 64'h0000_0000_0000_00FF;
                sb = 64'h0000_0000_0000_0080;
                wv = 8'd8;
            end
            SIZE_WORD:
            begin
                m  = 64'h0000_0000_0000_FFFF;
                sb = 64'h0000_0000_0000_8000;
                wv = 8'd16;
            end
            SIZE_QUAD:
            begin
                m  = 64'hFFFF_FFFF_FFFF_FFFF;
                sb = 64'h8000_0000_0000_0000;
                wv = 8'd64;
            end
            default:
            begin
                m  = 64'h0000_0000_FFFF_FFFF;
                sb = 64'h0000_0000_8000_0000;
                wv = 8'd32;
            end
        endcase
        is_quad = (eff_size == SIZE_QUAD);

        a = {{(DATA_W-OPA_W){1'b0}}, s1_a_reg} & m;
        b = s1_b_reg & m;

        // Adder and subtractor work on at most 32 bits.
        cin  = flags_reg.c && (op == OP_ADC || op == OP_SBC);
        sum  = {1'b0, b[LONG_W-1:0]} + {1'b0, a[LONG_W-1:0]}
             + {{LONG_W{1'b0}}, cin};
        diff = {1'b0, b[LONG_W-1:0]} - {1'b0, a[LONG_W-1:0]}
             - {{LONG_W{1'b0}}, cin};

        // Shift count as direction and magnitude; -128 gives 128.
        cnt_neg = s1_count_reg[COUNT_W-1];
        mag     = cnt_neg ? (8'd0 - s1_count_reg) : s1_count_reg;
        over_w  = (mag >= wv);

        sx   = is_quad ? b : {{LONG_W{b[LONG_W-1]}}, b[LONG_W-1:0]};
        shl  = (b << mag[5:0]) & m;
        sxl  = is_quad ? shl : {{LONG_W{shl[LONG_W-1]}}, shl[LONG_W-1:0]};
        chk  = DATA_W'($signed(sxl) >>> mag[5:0]) & m;
        rot2 = {b[LONG_W-1:0], b[LONG_W-1:0]} << s1_count_reg[4:0];

        r        = '0;
        v        = 1'b0;
        c        = flags_reg.c;
        valid_op = 1'b1;

        case (op)
            OP_ADD, OP_ADC:
            begin
                r = {{(DATA_W-LONG_W-1){1'b0}}, sum} & m;
                c = |({{(DATA_W-LONG_W-1){1'b0}}, sum} & {sb[DATA_W-2:0], 1'b0});
                v = |(~(a ^ b) & (a ^ r) & sb);
            end
            OP_SUB, OP_SBC:
            begin
                r = {{(DATA_W-LONG_W-1){1'b0}}, diff} & m;
                c = diff[LONG_W];
                v = |((a ^ b) & (~a ^ r) & sb);
            end
            OP_INC:
            begin
                r = (b + 64'd1) & m;
                v = (b == (sb - 64'd1));
                c = (r == '0);
            end
            OP_DEC:
            begin
                r = (b - 64'd1) & m;
                v = (b == sb);
                c = (b == '0);
            end
            OP_BIC: r = b & ~a & m;
            OP_BIS: r = (b | a) & m;
            OP_BIT: r = b & a;
            OP_XOR: r = (b ^ a) & m;
            OP_CLR: r = '0;
            OP_ASH:
            begin
                c = 1'b0;
                if (mag == 8'd0)
                begin
                    r = b;
                end
                else if (cnt_neg)
                begin
                    if (over_w)
                    begin
                        r = (|(b & sb)) ? m : '0;
                    end
                    else
                    begin
                        r = DATA_W'($signed(sx) >>> mag[5:0]) & m;
                    end
                end
                else
                begin
                    if (over_w)
                    begin
                        r = '0;
                        v = (b != '0);
                    end
                    else
                    begin
                        // Overflow when shifting back does not restore the source.
                        r = shl;
                        v = (chk != b);
                    end
                end
            end
            OP_ROT: r = {{(DATA_W-LONG_W){1'b0}}, rot2[DATA_W-1:LONG_W]};
            default: valid_op = 1'b0;
        endcase

        if (!valid_op)
        begin
            flags_next     = flags_reg;
            out_value_next = '0;
            out_trap_next  = 1'b0;
        end
        else
        begin
            if (op == OP_CLR)
            begin
                flags_next.n = 1'b0;
                flags_next.z = 1'b1;
            end
            else
            begin
                flags_next.n = |(r & sb);
                flags_next.z = (r == '0);
            end
            flags_next.v   = v;
            flags_next.c   = c;
            out_value_next = r;
            out_trap_next  = v && trap_en_reg;
        end
    end

    // ------------------------------------------------------------------
    // Control registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trap_en_reg   <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                trap_en_reg <= cfg_wr_data;
            end
            if (req.ready)
            begin
                s1_valid_reg <= req.valid;
            end
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                flags_reg <= flags_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_type_reg  <= req.req_type;
            s1_size_reg  <= req.operand_size;
            s1_a_reg     <= req.operand_a;
            s1_b_reg     <= req.operand_b;
            s1_count_reg <= req.shift_count;
        end
        if (advance)
        begin
            out_value_reg <= out_value_next;
            out_flags_reg <= flags_next;
            out_trap_reg  <= out_trap_next;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.result_value  = out_value_reg;
    assign rsp.flag_negative = out_flags_reg.n;
    assign rsp.flag_zero     = out_flags_reg.z;
    assign rsp.flag_overflow = out_flags_reg.v;
    assign rsp.flag_carry    = out_flags_reg.c;
    assign rsp.trap_request  = out_trap_reg;

endmodule
